// ----- rtl/core/sba_pkg.sv -----
// Shared types, codes and constants for the slab block allocator.
package sba_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_BLOCKS = 1024;
	localparam int DEF_ADDR_WIDTH = 48;

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int BIDX_W  = 10;
	localparam int CNT_W   = 11;
	localparam int BSIZE_W = 16;
	localparam int OADDR_W = 48;
	localparam int CIDX_W  = 2;

	localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};
	localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE  = 16'd16;
	localparam logic [CNT_W-1:0]   RST_BLOCKS_SPAN = 11'd1024;

	// Request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC       = 2'd0,
		OP_FREE_LOCAL  = 2'd1,
		OP_FREE_REMOTE = 2'd2,
		OP_RESET_SPAN  = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_BLOCK_SIZE    = 2'd0,
		CFG_BLOCKS_SPAN   = 2'd1,
		CFG_FIRST_ADDRESS = 2'd2
	} cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LINK,
		ST_MUL,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // latch the incoming request
		logic exec;      // apply the request to lists and counters
		logic link;      // finish a pop with the link read from memory
		logic mul;       // index times block size
		logic load_out;  // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic alloc_pop;   // a free list holds a block
		logic alloc_bump;  // a fresh block is left
		logic out_free;    // result register can take a new result
	} stat_t;

endpackage

// ----- rtl/core/sba_ram.sv -----
// Generic single-port RAM with registered read.
module sba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/core/sba_ctrl.sv -----
// Sequencing state machine for the slab block allocator.
module sba_ctrl
	import sba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.op == OP_ALLOC && stat.alloc_pop) begin
					state_d = ST_LINK;
				end else if (stat.op == OP_ALLOC && stat.alloc_bump) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				cmd.mul  = 1'b1;
				state_d  = ST_RESULT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					in_stall     = 1'b0;
					if (in_valid) begin
						cmd.take = 1'b1;
						state_d  = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A link update only follows the step that issued the memory read
	a_link_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINK |-> $past(state_q) == ST_EXEC)
		else $error("link step without a preceding exec step");

	// A bump multiply only follows the exec step
	a_mul_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> $past(state_q) == ST_EXEC)
		else $error("multiply step without a preceding exec step");

endmodule

// ----- rtl/core/sba_dpath.sv -----
// Datapath: free lists, link memory, counters, address math, result register.
module sba_dpath
	import sba_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration
	input  logic                cfg_valid,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [OADDR_W-1:0]  cfg_data,
	// Request payload
	input  logic [OP_W-1:0]     operation,
	input  logic [BIDX_W-1:0]   block_index,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [BIDX_W-1:0]   granted_index,
	output logic [OADDR_W-1:0]  granted_address,
	output logic [CNT_W-1:0]    live_blocks,
	output logic                span_full,
	output logic                span_empty,
	// Controller
	input  cmd_t                cmd,
	output stat_t               stat
);

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int PROD_W = IDX_W + BSIZE_W;
	localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

	// Configuration registers
	logic [BSIZE_W-1:0] bsize_q;
	logic [CNT_W-1:0]   span_blocks_q;
	logic [OADDR_W-1:0] first_addr_q;

	// Request registers
	op_t               op_q;
	logic [BIDX_W-1:0] bi_q;

	// List and counter state
	logic [IDX_W-1:0] local_head_q, def_head_q;
	logic             local_valid_q, def_valid_q;
	logic [CNT_W-1:0] live_q, def_cnt_q, bump_q;

	// Per-request working registers
	logic [IDX_W-1:0]  gidx_q;
	logic              got_q, exh_q;
	logic [PROD_W-1:0] prod_q;
	logic              out_valid_q;

	logic              free_ok, bump_ok, free_push;
	logic [IDX_W-1:0]  free_idx, ram_addr, ram_wdata, ram_rdata;
	logic [63:0]       addr_sum;
	logic [CNT_W-1:0]  live_inc;

	// Request decode
	assign free_ok  = (32'(bi_q) < MAX_BLOCKS);
	assign free_idx = IDX_W'(bi_q);
	assign bump_ok  = (bump_q < span_blocks_q) && (32'(bump_q) < MAX_BLOCKS);
	assign live_inc = (live_q != CNT_MAX) ? live_q + 1'b1 : live_q;

	assign free_push = cmd.exec && free_ok &&
		(op_q == OP_FREE_LOCAL || op_q == OP_FREE_REMOTE);

	// Link memory port: pop reads the head, push writes the freed block's link
	always_comb begin
		if (op_q == OP_ALLOC) begin
			ram_addr = local_valid_q ? local_head_q : def_head_q;
		end else begin
			ram_addr = free_idx;
		end
		if (op_q == OP_FREE_LOCAL) begin
			ram_wdata = local_valid_q ? local_head_q : free_idx;
		end else begin
			ram_wdata = def_valid_q ? def_head_q : free_idx;
		end
	end

	sba_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (free_push),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q       <= RST_BLOCK_SIZE;
			span_blocks_q <= RST_BLOCKS_SPAN;
			first_addr_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BLOCK_SIZE:    bsize_q       <= BSIZE_W'(cfg_data);
				CFG_BLOCKS_SPAN:   span_blocks_q <= CNT_W'(cfg_data);
				CFG_FIRST_ADDRESS: first_addr_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= op_t'(operation);
			bi_q <= block_index;
		end
	end

	// List heads and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_head_q  <= '0;
			local_valid_q <= 1'b0;
			def_head_q    <= '0;
			def_valid_q   <= 1'b0;
			live_q        <= '0;
			def_cnt_q     <= '0;
			bump_q        <= '0;
			got_q         <= 1'b0;
			exh_q         <= 1'b0;
		end else if (cmd.exec) begin
			got_q <= 1'b0;
			exh_q <= 1'b0;
			case (op_q)
				OP_ALLOC: begin
					if (local_valid_q) begin
						got_q <= 1'b1;
					end else if (def_valid_q) begin
						// take over the whole deferred list
						local_head_q  <= def_head_q;
						local_valid_q <= 1'b1;
						live_q        <= (live_q >= def_cnt_q) ? live_q - def_cnt_q : '0;
						def_head_q    <= '0;
						def_valid_q   <= 1'b0;
						def_cnt_q     <= '0;
						got_q         <= 1'b1;
					end else if (bump_ok) begin
						bump_q <= bump_q + 1'b1;
						live_q <= live_inc;
						got_q  <= 1'b1;
					end else begin
						exh_q <= 1'b1;
					end
				end
				OP_FREE_LOCAL: begin
					if (free_ok) begin
						local_head_q  <= free_idx;
						local_valid_q <= 1'b1;
						if (live_q != '0) begin
							live_q <= live_q - 1'b1;
						end
					end
				end
				OP_FREE_REMOTE: begin
					if (free_ok) begin
						def_head_q  <= free_idx;
						def_valid_q <= 1'b1;
						if (def_cnt_q != CNT_MAX) begin
							def_cnt_q <= def_cnt_q + 1'b1;
						end
					end
				end
				OP_RESET_SPAN: begin
					local_head_q  <= '0;
					local_valid_q <= 1'b0;
					def_head_q    <= '0;
					def_valid_q   <= 1'b0;
					live_q        <= '0;
					def_cnt_q     <= '0;
					bump_q        <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.link) begin
			// pop completes: a self link marks the list end
			if (ram_rdata == gidx_q) begin
				local_valid_q <= 1'b0;
			end else begin
				local_head_q <= ram_rdata;
			end
			live_q <= live_inc;
		end
	end

	// Granted index and address product
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (local_valid_q) begin
				gidx_q <= local_head_q;
			end else if (def_valid_q) begin
				gidx_q <= def_head_q;
			end else begin
				gidx_q <= IDX_W'(bump_q);
			end
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(gidx_q) * PROD_W'(bsize_q);
		end
	end

	assign addr_sum = 64'(first_addr_q) + 64'(prod_q);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status          <= exh_q;
			granted_index   <= got_q ? BIDX_W'(gidx_q) : '0;
			granted_address <= got_q ? OADDR_W'(addr_sum & ADDR_MASK) : '0;
			live_blocks     <= live_q;
			span_full       <= (live_q == span_blocks_q) && (def_cnt_q == '0);
			span_empty      <= (live_q == def_cnt_q);
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller
	assign stat.op         = op_q;
	assign stat.alloc_pop  = local_valid_q || def_valid_q;
	assign stat.alloc_bump = bump_ok;
	assign stat.out_free   = !out_valid_q || !out_stall;

	// A local free in range always leaves the local list non-empty
	a_local_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_FREE_LOCAL && free_ok |=> local_valid_q)
		else $error("local list empty after local free");

	// An allocate with nothing left grants no block and flags exhaustion
	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_ALLOC && !stat.alloc_pop && !bump_ok |=> !got_q && exh_q)
		else $error("exhausted allocate granted a block");

	// A deferred move hands the list over and clears the deferred count
	a_def_move: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_ALLOC && !local_valid_q && def_valid_q
		|=> local_valid_q && !def_valid_q && def_cnt_q == '0)
		else $error("deferred list not moved on allocate");

endmodule

// ----- rtl/core/slab_block_allocator_core.sv -----
// A free, span reset or exhausted allocate passes through the exec and result states after
// the request is accepted; a granting allocate adds a link state (pop: link update and the
// multiply together) or a multiply state (bump). The result state holds while the result
// register is full and stalled, and takes the next request while the loaded result waits.
// Reset (arst_n low) empties both lists, clears counters and bump index, and restores
// configuration defaults; the link memory is not cleared and needs no clearing pass.
module slab_block_allocator_core
	import sba_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [OADDR_W-1:0] cfg_data,
	// Request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [BIDX_W-1:0]  block_index,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [BIDX_W-1:0]  granted_index,
	output logic [OADDR_W-1:0] granted_address,
	output logic [CNT_W-1:0]   live_blocks,
	output logic               span_full,
	output logic               span_empty
);

	cmd_t  cmd;
	stat_t stat;

	// Configuration is always writable
	assign cfg_ready = 1'b1;

	sba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	sba_dpath #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.block_index    (block_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_index  (granted_index),
		.granted_address(granted_address),
		.live_blocks    (live_blocks),
		.span_full      (span_full),
		.span_empty     (span_empty),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

// ----- verif/slab_block_allocator_core_tb.sv -----
// Self-checking testbench for slab_block_allocator_core: directed table, random traffic.
module slab_block_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sba_pkg::*;

	localparam int MAX_IDX        = DEF_MAX_BLOCKS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_REPORTS    = 10;
	localparam int NUM_SEGS       = 6;
	localparam int SEG_ITEMS      = 169;
	localparam int BUSY_PCT       = 59;
	localparam int LIGHT_PCT      = 6;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_t;

	// One result of the allocator, field for field
	typedef struct packed {
		logic               status;
		logic [BIDX_W-1:0]  gidx;
		logic [OADDR_W-1:0] gaddr;
		logic [CNT_W-1:0]   live;
		logic               full;
		logic               empty;
	} grant_t;

	typedef struct {
		row_kind_t          kind;
		op_t                op;
		logic [BIDX_W-1:0]  bidx;
		cfg_idx_t           ci;
		logic [OADDR_W-1:0] cdata;
		grant_t             want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [OADDR_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    operation = '0;
	logic [BIDX_W-1:0]  block_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               status;
	logic [BIDX_W-1:0]  granted_index;
	logic [OADDR_W-1:0] granted_address;
	logic [CNT_W-1:0]   live_blocks;
	logic               span_full;
	logic               span_empty;

	slab_block_allocator_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.block_index     (block_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_index   (granted_index),
		.granted_address (granted_address),
		.live_blocks     (live_blocks),
		.span_full       (span_full),
		.span_empty      (span_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Allocator shadow: lists, counters and registers
	logic [BIDX_W-1:0]  next_free [MAX_IDX];
	logic [BIDX_W-1:0]  lhead = '0;
	logic [BIDX_W-1:0]  dhead = '0;
	logic               lval = 1'b0;
	logic               dval = 1'b0;
	logic [CNT_W-1:0]   live_cnt = '0;
	logic [CNT_W-1:0]   dfr_cnt = '0;
	logic [CNT_W-1:0]   bump_ptr = '0;
	logic [BSIZE_W-1:0] m_bsize = RST_BLOCK_SIZE;
	logic [CNT_W-1:0]   m_span = RST_BLOCKS_SPAN;
	logic [OADDR_W-1:0] m_base = '0;

	grant_t    grant_q[$];
	stim_row_t stim_table[$];
	int        held[$];
	int        snd_pct = 0;
	int        rcv_pct = 0;
	int        err_count = 0;
	int        quiet = 0;
	int        n_checked = 0;
	int        n_granted = 0;
	int        n_exhausted = 0;
	int        n_free_local = 0;
	int        n_free_remote = 0;
	int        n_resets = 0;
	int        n_cfg_writes = 0;

	// Take the local head; a self-linked block ends the list
	function automatic logic [BIDX_W-1:0] pop_local();
		logic [BIDX_W-1:0] b;
		b = lhead;
		if (next_free[b] == b) lval = 1'b0;
		else lhead = next_free[b];
		if (live_cnt != CNT_MAX) live_cnt = live_cnt + 1'b1;
		return b;
	endfunction

	function automatic grant_t alloc_predict(op_t op, logic [BIDX_W-1:0] bidx);
		grant_t           r;
		logic [CNT_W-1:0] cap;
		logic [63:0]      addr;
		r = '0;
		case (op)
		OP_ALLOC: begin
			cap = (m_span < CNT_W'(MAX_IDX)) ? m_span : CNT_W'(MAX_IDX);
			if (lval) begin
				r.gidx = pop_local();
			end else if (dval) begin
				// adopt the whole deferred list, then pop
				lhead = dhead;
				lval = 1'b1;
				live_cnt = (live_cnt >= dfr_cnt) ? live_cnt - dfr_cnt : '0;
				dhead = '0;
				dval = 1'b0;
				dfr_cnt = '0;
				r.gidx = pop_local();
			end else if (bump_ptr < cap) begin
				r.gidx = bump_ptr[BIDX_W-1:0];
				bump_ptr = bump_ptr + 1'b1;
				if (live_cnt != CNT_MAX) live_cnt = live_cnt + 1'b1;
			end else begin
				r.status = 1'b1;
			end
			if (!r.status) begin
				addr = 64'(m_base) + 64'(r.gidx) * 64'(m_bsize);
				r.gaddr = addr[OADDR_W-1:0];
			end
		end
		OP_FREE_LOCAL: begin
			next_free[bidx] = lval ? lhead : bidx;
			lhead = bidx;
			lval = 1'b1;
			if (live_cnt != '0) live_cnt = live_cnt - 1'b1;
		end
		OP_FREE_REMOTE: begin
			next_free[bidx] = dval ? dhead : bidx;
			dhead = bidx;
			dval = 1'b1;
			if (dfr_cnt != CNT_MAX) dfr_cnt = dfr_cnt + 1'b1;
		end
		default: begin
			lhead = '0;
			lval = 1'b0;
			dhead = '0;
			dval = 1'b0;
			live_cnt = '0;
			dfr_cnt = '0;
			bump_ptr = '0;
		end
		endcase
		r.live = live_cnt;
		r.full = (live_cnt == m_span) && (dfr_cnt == '0);
		r.empty = (live_cnt == dfr_cnt);
		return r;
	endfunction

	function automatic string fmt_grant(grant_t g);
		return $sformatf("status=%0d idx=%0d addr=%h live=%0d full=%0d empty=%0d",
			g.status, g.gidx, g.gaddr, g.live, g.full, g.empty);
	endfunction

	// Directed table rows
	function automatic void tab_req(op_t op, logic [BIDX_W-1:0] b);
		stim_row_t row;
		row = '{ROW_REQ, op, b, CFG_BLOCK_SIZE, '0, '0};
		stim_table.push_back(row);
	endfunction

	function automatic void tab_chk(op_t op, logic [BIDX_W-1:0] b, logic st,
			logic [BIDX_W-1:0] gi, logic [OADDR_W-1:0] ga, logic [CNT_W-1:0] lv,
			logic fu, logic em);
		stim_row_t row;
		grant_t    w;
		w = '{st, gi, ga, lv, fu, em};
		row = '{ROW_CHK, op, b, CFG_BLOCK_SIZE, '0, w};
		stim_table.push_back(row);
	endfunction

	function automatic void tab_cfg(cfg_idx_t ci, logic [OADDR_W-1:0] d);
		stim_row_t row;
		row = '{ROW_CFG, OP_ALLOC, '0, ci, d, '0};
		stim_table.push_back(row);
	endfunction

	task automatic note_fail(string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
		IDLE_SENDER: begin
			snd_pct = BUSY_PCT;
			rcv_pct = 0;
		end
		IDLE_RECEIVER: begin
			snd_pct = 0;
			rcv_pct = BUSY_PCT;
		end
		IDLE_BOTH: begin
			snd_pct = LIGHT_PCT;
			rcv_pct = LIGHT_PCT;
		end
		default: begin
			snd_pct = 0;
			rcv_pct = 0;
		end
		endcase
	endtask

	// Entered and left at a falling edge; records the expected result on acceptance
	task automatic send_request(op_t op, logic [BIDX_W-1:0] bidx, bit typed, grant_t want,
			output grant_t pred);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < snd_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		block_index <= bidx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = alloc_predict(op, bidx);
		grant_q.push_back(typed ? want : pred);
		case (op)
		OP_ALLOC: begin
			if (pred.status) n_exhausted++;
			else n_granted++;
		end
		OP_FREE_LOCAL:  n_free_local++;
		OP_FREE_REMOTE: n_free_remote++;
		default:        n_resets++;
		endcase
		@(negedge clk);
	endtask

	task automatic send_plain(op_t op, logic [BIDX_W-1:0] bidx);
		grant_t p;
		send_request(op, bidx, 1'b0, '0, p);
	endtask

	// Hold off requests until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (grant_q.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t ci, logic [OADDR_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= ci;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (ci)
		CFG_BLOCK_SIZE:    m_bsize = d[BSIZE_W-1:0];
		CFG_BLOCKS_SPAN:   m_span = d[CNT_W-1:0];
		CFG_FIRST_ADDRESS: m_base = d;
		default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
	endtask

	task automatic program_span(logic [BSIZE_W-1:0] bsize, logic [CNT_W-1:0] span,
			logic [OADDR_W-1:0] base);
		drain();
		write_reg(CFG_BLOCK_SIZE, OADDR_W'(bsize));
		write_reg(CFG_BLOCKS_SPAN, OADDR_W'(span));
		write_reg(CFG_FIRST_ADDRESS, base);
	endtask

	function automatic logic [BIDX_W-1:0] any_index();
		return BIDX_W'($urandom_range(0, MAX_IDX - 1));
	endfunction

	// Mostly allocate/free of blocks we hold; some noise, double frees and span resets
	task automatic random_item();
		grant_t            pred;
		int                pick;
		int                pos;
		op_t               op;
		logic [BIDX_W-1:0] bidx;
		pick = $urandom_range(0, 99);
		bidx = any_index();
		if (pick < 15) begin
			op = op_t'($urandom_range(0, 3));
		end else if (pick == 15) begin
			op = OP_RESET_SPAN;
		end else if (held.size() == 0 || pick < 58) begin
			op = OP_ALLOC;
		end else begin
			pos = $urandom_range(0, held.size() - 1);
			bidx = BIDX_W'(held[pos]);
			held.delete(pos);
			op = (pick < 86) ? OP_FREE_LOCAL : OP_FREE_REMOTE;
		end
		send_request(op, bidx, 1'b0, '0, pred);
		if (op == OP_ALLOC && !pred.status) held.push_back(int'(pred.gidx));
		if (op == OP_RESET_SPAN) held.delete();
	endtask

	// Receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_pct);
	end

	// Result checker
	task automatic check_result(grant_t got);
		grant_t want;
		string  fields;
		n_checked++;
		if (grant_q.size() == 0) begin
			note_fail($sformatf("result with none expected: %s", fmt_grant(got)));
		end else begin
			want = grant_q.pop_front();
			fields = "";
			if (got.status !== want.status) fields = {fields, " status"};
			if (got.gidx !== want.gidx) fields = {fields, " granted_index"};
			if (got.gaddr !== want.gaddr) fields = {fields, " granted_address"};
			if (got.live !== want.live) fields = {fields, " live_blocks"};
			if (got.full !== want.full) fields = {fields, " span_full"};
			if (got.empty !== want.empty) fields = {fields, " span_empty"};
			if (fields != "")
				note_fail($sformatf("result %0d wrong%s\n  expected %s\n  actual   %s",
					n_checked, fields, fmt_grant(want), fmt_grant(got)));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result('{status, granted_index, granted_address, live_blocks,
				span_full, span_empty});
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles, %0d results outstanding",
					quiet, grant_q.size());
				$display("slab_block_allocator_core test failed");
				$finish;
			end
		end
	end

	initial begin
		grant_t pred;

		// Directed part, reset defaults: size 16, span 1024, base 0
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd0, 48'd0, 11'd1, 1'b0, 1'b0);
		tab_chk(OP_ALLOC, 10'd1023, 1'b0, 10'd1, 48'd16, 11'd2, 1'b0, 1'b0);
		tab_chk(OP_FREE_LOCAL, 10'd0, 1'b0, 10'd0, 48'd0, 11'd1, 1'b0, 1'b0);
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd0, 48'd0, 11'd2, 1'b0, 1'b0);
		tab_chk(OP_FREE_REMOTE, 10'd1, 1'b0, 10'd0, 48'd0, 11'd2, 1'b0, 1'b0);
		// local list empty: deferred list is adopted
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd1, 48'd16, 11'd2, 1'b0, 1'b0);
		// double free of the top index cuts the list after it
		tab_req(OP_FREE_LOCAL, 10'd1023);
		tab_req(OP_FREE_LOCAL, 10'd1023);
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd1023, 48'd16368, 11'd1, 1'b0, 1'b0);
		tab_req(OP_ALLOC, 10'd512);
		tab_chk(OP_RESET_SPAN, 10'd1023, 1'b0, 10'd0, 48'd0, 11'd0, 1'b0, 1'b1);
		// live count holds at zero
		tab_chk(OP_FREE_LOCAL, 10'd5, 1'b0, 10'd0, 48'd0, 11'd0, 1'b0, 1'b1);
		tab_chk(OP_FREE_REMOTE, 10'd7, 1'b0, 10'd0, 48'd0, 11'd0, 1'b0, 1'b0);
		tab_req(OP_FREE_REMOTE, 10'd8);
		tab_req(OP_ALLOC, 10'd0);
		// deferred count above live count: subtraction clamps at zero
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd8, 48'd128, 11'd1, 1'b0, 1'b0);
		tab_req(OP_ALLOC, 10'd0);
		// one-block span, widest block, top address
		tab_cfg(CFG_BLOCKS_SPAN, 48'd1);
		tab_cfg(CFG_BLOCK_SIZE, 48'd65535);
		tab_cfg(CFG_FIRST_ADDRESS, 48'hFFFF_FFFF_FFFF);
		tab_chk(OP_RESET_SPAN, 10'd0, 1'b0, 10'd0, 48'd0, 11'd0, 1'b0, 1'b1);
		tab_chk(OP_ALLOC, 10'd0, 1'b0, 10'd0, 48'hFFFF_FFFF_FFFF, 11'd1, 1'b1, 1'b0);
		tab_chk(OP_ALLOC, 10'd0, 1'b1, 10'd0, 48'd0, 11'd1, 1'b1, 1'b0);
		tab_chk(OP_FREE_REMOTE, 10'd0, 1'b0, 10'd0, 48'd0, 11'd1, 1'b0, 1'b1);
		// address wraps past the top
		tab_req(OP_FREE_LOCAL, 10'd1023);
		tab_req(OP_ALLOC, 10'd0);
		tab_req(OP_ALLOC, 10'd0);
		tab_req(OP_ALLOC, 10'd0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle(IDLE_BOTH);
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				drain();
				write_reg(stim_table[i].ci, stim_table[i].cdata);
			end else begin
				send_request(stim_table[i].op, stim_table[i].bidx,
					stim_table[i].kind == ROW_CHK, stim_table[i].want, pred);
			end
		end

		// Random traffic over several register settings
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			set_idle(idle_mode_t'(seg % 4));
			case (seg)
			0:       program_span(16'd1, 11'd1024, '0);
			1:       program_span(16'd65535, 11'd1, 48'hFFFF_FFFF_FFFF);
			2:       program_span(BSIZE_W'($urandom_range(1, 65535)), 11'd8,
					OADDR_W'({$urandom(), $urandom()}));
			3:       program_span(BSIZE_W'($urandom_range(1, 65535)), 11'd1024,
					OADDR_W'({$urandom(), $urandom()}));
			4:       program_span(BSIZE_W'($urandom_range(1, 65535)),
					CNT_W'($urandom_range(1, 64)), OADDR_W'({$urandom(), $urandom()}));
			default: program_span(16'd65535, 11'd1024, 48'hFFFF_FFFF_FFFF);
			endcase
			send_plain(OP_RESET_SPAN, any_index());
			held.delete();
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if (seg == NUM_SEGS - 1 && k == SEG_ITEMS / 2) drain();
				random_item();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d grants, %0d exhausted allocates, %0d local and %0d remote frees",
			n_granted, n_exhausted, n_free_local, n_free_remote);
		$display("%0d span resets, %0d results compared, %0d register writes",
			n_resets, n_checked, n_cfg_writes);
		if (err_count == 0 && grant_q.size() == 0)
			$display("slab_block_allocator_core test passed");
		else
			$display("slab_block_allocator_core test failed");
		$finish;
	end

endmodule

// ----- slab_block_allocator_core.f -----
rtl/core/sba_pkg.sv
rtl/core/sba_ram.sv
rtl/core/sba_ctrl.sv
rtl/core/sba_dpath.sv
rtl/core/slab_block_allocator_core.sv
verif/slab_block_allocator_core_tb.sv
